// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; clock and reset names follow the project ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold outside of reset.
`define SFR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
package sfr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ReplMax    = 8;
  localparam int unsigned BurstMax   = (PatternMax > ReplMax) ? PatternMax : ReplMax;

  localparam int unsigned FillW  = $clog2(PatternMax + 1);
  localparam int unsigned RlenW  = $clog2(ReplMax + 1);
  // data bytes plus the closing marker
  localparam int unsigned CntW   = $clog2(BurstMax + 2);
  localparam int unsigned BIdxW  = (BurstMax > 1) ? $clog2(BurstMax) : 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPattern  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPlen     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRepl     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRlen     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCaseSens = 3'd4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  plen;
    logic [63:0] repl;
    logic [3:0]  rlen;
    logic        case_sens;
  } cfg_t;

  typedef struct packed {
    byte_t [BurstMax-1:0] bytes;
    logic  [CntW-1:0]     cnt;
    logic                 marker;
    logic                 any;
  } burst_t;

  function automatic byte_t fold_upper(byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== src/sfr_window.sv =====
module sfr_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output sfr_pkg::burst_t burst_o
);
  import sfr_pkg::*;

  `include "assert_macros.svh"

  byte_t [PatternMax-1:0] win_q, win_d;
  logic  [FillW-1:0]      fill_q, fill_d;
  logic                   seen_q, seen_d;

  byte_t [BurstMax-1:0]   wext;
  logic  [FillW-1:0]      plen, fillc, n, e;
  logic  [RlenW-1:0]      rlen;
  logic  [3:0]            plen4, rlen4;
  logic                   match, do_rep;
  byte_t                  a, p;

  always_comb begin
    // out-of-range lengths clamp
    plen4 = cfg_i.plen;
    if (plen4 == 4'd0) begin
      plen4 = 4'd1;
    end else if (plen4 > 4'(PatternMax)) begin
      plen4 = 4'(PatternMax);
    end
    plen = FillW'(plen4);

    rlen4 = cfg_i.rlen;
    if (rlen4 > 4'(ReplMax)) begin
      rlen4 = 4'(ReplMax);
    end
    rlen = RlenW'(rlen4);

    fillc = (fill_q > FillW'(PatternMax - 1)) ? FillW'(PatternMax - 1) : fill_q;
    n     = fillc + FillW'(1);

    // held bytes with the new byte appended
    for (int k = 0; k < BurstMax; k++) begin
      wext[k] = 8'h00;
      if (k < PatternMax) begin
        wext[k] = (FillW'(k) < fillc) ? win_q[k] : data_byte_i;
      end
    end

    match = 1'b1;
    for (int k = 0; k < PatternMax; k++) begin
      a = wext[k];
      p = cfg_i.pattern[8*k +: 8];
      if (!cfg_i.case_sens) begin
        a = fold_upper(a);
        p = fold_upper(p);
      end
      if (FillW'(k) < plen && a != p) begin
        match = 1'b0;
      end
    end

    do_rep = (n == plen) && match;
    if (n > plen) begin
      e = n - plen + FillW'(1);
    end else if (n == plen && !match) begin
      e = FillW'(1);
    end else begin
      e = '0;
    end

    // drop the emitted bytes off the front
    for (int k = 0; k < PatternMax; k++) begin
      win_d[k] = wext[k];
      for (int s = 0; s < PatternMax - k; s++) begin
        if (e == FillW'(s)) begin
          win_d[k] = wext[k+s];
        end
      end
    end

    fill_d = (last_byte_i || do_rep) ? '0 : n - e;
    seen_d = last_byte_i ? 1'b0 : (seen_q | do_rep);

    for (int k = 0; k < BurstMax; k++) begin
      burst_o.bytes[k] = do_rep ? cfg_i.repl[8*k +: 8] : wext[k];
    end
    if (do_rep) begin
      burst_o.cnt = CntW'(rlen);
    end else if (last_byte_i) begin
      burst_o.cnt = CntW'(n);
    end else begin
      burst_o.cnt = CntW'(e);
    end
    burst_o.marker = last_byte_i;
    burst_o.any    = seen_q | do_rep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

  `SFR_NEVER(a_fill_range, fill_q > FillW'(PatternMax - 1), "window overfilled")
  `SFR_ASSERT(a_end_clears, accept_i && last_byte_i |=> fill_q == '0 && !seen_q,
              "state not cleared after last byte")
  `SFR_ASSERT(a_rep_empties, accept_i && do_rep |=> fill_q == '0,
              "window not emptied after replacement")

endmodule

// ===== src/sfr_burst.sv =====
module sfr_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sfr_pkg::burst_t burst_i,
  input  logic            out_stall_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            byte_present_o,
  output logic            string_done_o,
  output logic            replaced_any_o
);
  import sfr_pkg::*;

  `include "assert_macros.svh"

  byte_t [BurstMax-1:0] bytes_q;
  logic  [CntW-1:0]     cnt_q;
  logic                 any_q;
  logic  [CntW-1:0]     idx_q, idx_d;
  logic  [CntW-1:0]     rem_q, rem_d;
  logic                 present;

  assign out_valid_o = (rem_q != '0);
  // free, or the final entry leaves this cycle
  assign can_load_o  = (rem_q == '0) || (rem_q == CntW'(1) && !out_stall_i);

  assign present        = (idx_q < cnt_q);
  assign out_byte_o     = present ? bytes_q[idx_q[BIdxW-1:0]] : 8'h00;
  assign byte_present_o = present;
  assign string_done_o  = !present;
  assign replaced_any_o = !present && any_q;

  always_comb begin
    idx_d = idx_q;
    rem_d = rem_q;
    if (load_i) begin
      idx_d = '0;
      rem_d = burst_i.cnt + CntW'(burst_i.marker);
    end else if (out_valid_o && !out_stall_i) begin
      idx_d = idx_q + CntW'(1);
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      rem_q <= '0;
    end else begin
      idx_q <= idx_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      cnt_q   <= burst_i.cnt;
      any_q   <= burst_i.any;
    end
  end

  `SFR_ASSERT(a_load_ok, load_i |-> can_load_o, "burst loaded over pending results")
  `SFR_NEVER(a_rem_range, rem_q > CntW'(BurstMax + 1), "burst count out of range")
  `SFR_ASSERT(a_hold_on_stall, rem_q != '0 && out_stall_i |=> $stable(idx_q),
              "drain index moved under stall")

endmodule

// ===== src/stream_find_and_replace_unit.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------------
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
// input    | in        | in_valid_i / in_stall_o  | data_byte_i, last_byte_i
// output   | out       | out_valid_o / out_stall_i| out_byte_o, byte_present_o,
//          |           |                          | string_done_o, replaced_any_o
//
// One input byte is taken per cycle when it produces at most one result and
// the output is not stalled. An item that produces r results (0..9) holds
// the burst drain register until all r have transferred, and the next byte
// is taken in the cycle the final result of the burst transfers.
// Reset (rst_ni, async, active low) empties the window and the burst; no
// clearing pass is needed. A stall on the output freezes the burst in place
// and holds in_stall_o high while any result is pending.
module stream_find_and_replace_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  // source bytes
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  // rewritten bytes and closing marker
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         byte_present_o,
  output logic                         string_done_o,
  output logic                         replaced_any_o
);
  import sfr_pkg::*;

  cfg_t   cfg_q;
  burst_t burst;
  logic   can_load;
  logic   accept;

  // Register file; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern   <= '0;
      cfg_q.plen      <= 4'd1;
      cfg_q.repl      <= '0;
      cfg_q.rlen      <= '0;
      cfg_q.case_sens <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPattern:  cfg_q.pattern   <= cfg_data_i;
        CfgPlen:     cfg_q.plen      <= cfg_data_i[3:0];
        CfgRepl:     cfg_q.repl      <= cfg_data_i;
        CfgRlen:     cfg_q.rlen      <= cfg_data_i[3:0];
        CfgCaseSens: cfg_q.case_sens <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A transfer on the input happens only when the burst register can take
  // the results of this byte.
  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;

  // Window compare and next-state; results of the byte leave as one burst.
  sfr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .burst_o     (burst)
  );

  // Burst register drained one result per output transfer.
  sfr_burst u_burst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .burst_i        (burst),
    .out_stall_i    (out_stall_i),
    .can_load_o     (can_load),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .string_done_o  (string_done_o),
    .replaced_any_o (replaced_any_o)
  );

endmodule

// ===== dv/sfr_rewrite_checker.sv =====
// Watches the config, input and output channels of the find-and-replace unit,
// predicts the rewritten byte stream and compares every output transfer.
module sfr_rewrite_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [7:0]                   out_byte_i,
  input  logic                         byte_present_i,
  input  logic                         string_done_i,
  input  logic                         replaced_any_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  present;
    logic  done;
    logic  any;
  } rewrite_t;

  rewrite_t    rewritten_q[$];
  cfg_t        cfg_q;
  byte_t       window_q [PatternMax];
  int unsigned fill_q;
  logic        seen_q;
  int          errors = 0;

  function automatic byte_t to_upper(byte_t c);
    return (c >= "a" && c <= "z") ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic window_hit(int unsigned len);
    byte_t a, p;
    for (int unsigned k = 0; k < len; k++) begin
      a = window_q[k];
      p = cfg_q.pattern[8*k +: 8];
      if (!cfg_q.case_sens) begin
        a = to_upper(a);
        p = to_upper(p);
      end
      if (a != p) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_result(byte_t b, logic present, logic done, logic any);
    rewritten_q.push_back('{data: b, present: present, done: done, any: any});
  endtask

  // pass the oldest window bytes through untouched
  task automatic emit_oldest(int unsigned count);
    int unsigned n;
    n = (count > fill_q) ? fill_q : count;
    for (int unsigned k = 0; k < n; k++) push_result(window_q[k], 1'b1, 1'b0, 1'b0);
    for (int unsigned k = n; k < fill_q; k++) window_q[k-n] = window_q[k];
    fill_q -= n;
  endtask

  task automatic rewrite_byte(byte_t b, logic is_last);
    int unsigned plen, rlen;
    plen = cfg_q.plen;
    rlen = cfg_q.rlen;
    if (plen < 1) plen = 1;
    if (plen > PatternMax) plen = PatternMax;
    if (rlen > ReplMax) rlen = ReplMax;

    if (fill_q > PatternMax - 1) fill_q = PatternMax - 1;
    window_q[fill_q] = b;
    fill_q++;

    if (fill_q > plen) begin
      emit_oldest(fill_q - plen + 1);
    end else if (fill_q == plen) begin
      if (window_hit(plen)) begin
        for (int unsigned k = 0; k < rlen; k++) begin
          push_result(cfg_q.repl[8*k +: 8], 1'b1, 1'b0, 1'b0);
        end
        fill_q = 0;
        seen_q = 1'b1;
      end else begin
        emit_oldest(1);
      end
    end

    if (is_last) begin
      emit_oldest(fill_q);
      push_result(8'h00, 1'b0, 1'b1, seen_q);
      fill_q = 0;
      seen_q = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t ns: rewrite check: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rewrite_t want_r;
    if (!rst_ni) begin
      cfg_q  = '{pattern: '0, plen: 4'd1, repl: '0, rlen: 4'd0, case_sens: 1'b1};
      fill_q = 0;
      seen_q = 1'b0;
      rewritten_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPattern:  cfg_q.pattern   = cfg_data_i;
          CfgPlen:     cfg_q.plen      = cfg_data_i[3:0];
          CfgRepl:     cfg_q.repl      = cfg_data_i;
          CfgRlen:     cfg_q.rlen      = cfg_data_i[3:0];
          CfgCaseSens: cfg_q.case_sens = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rewrite_byte(data_byte_i, last_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch("unexpected result, out_byte", 0, out_byte_i);
        end else begin
          want_r = rewritten_q.pop_front();
          if (out_byte_i !== want_r.data)
            report_mismatch("out_byte", want_r.data, out_byte_i);
          if (byte_present_i !== want_r.present)
            report_mismatch("byte_present", want_r.present, byte_present_i);
          if (string_done_i !== want_r.done)
            report_mismatch("string_done", want_r.done, string_done_i);
          if (replaced_any_i !== want_r.any)
            report_mismatch("replaced_any", want_r.any, replaced_any_i);
        end
      end
    end
    mismatch_count_o <= errors;
    pending_o        <= rewritten_q.size();
  end

endmodule

// ===== dv/stream_find_and_replace_unit_test.sv =====
// Stimulus and verdict for the find-and-replace unit; all checking lives in
// the rewrite checker instantiated beside the DUT.
module stream_find_and_replace_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  // generous bound: every item at 9 results, each result behind a long stall
  localparam int unsigned CycleLimit    = 400000;
  // idle cycles after the last expected result; bytes still held in the window stay there until more input
  localparam int unsigned SettleCycles  = 16;
  // receiver hold-off long enough to back the unit up into its input
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned BytesPerPhase = 24;

  typedef byte_t byte_q_t[$];

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          out_byte_o;
  logic                byte_present_o;
  logic                string_done_o;
  logic                replaced_any_o;

  int          mismatch_count;
  int          pending_results;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_off_req  = 1'b0;

  stream_find_and_replace_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_present_o(byte_present_o),
    .string_done_o (string_done_o),
    .replaced_any_o(replaced_any_o)
  );

  sfr_rewrite_checker u_rewrite_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .byte_present_i  (byte_present_o),
    .string_done_i   (string_done_o),
    .replaced_any_i  (replaced_any_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("stream_find_and_replace_unit_test: done, errors");
    $finish;
  end

  // Receiver: random stalls at stall_pct, or one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // text to bytes, first character first
  function automatic byte_q_t text_bytes(string text);
    byte_q_t q;
    for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
    return q;
  endfunction

  // text to a register image, first character in bits 7:0
  function automatic logic [63:0] pack_text(string text);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < text.len() && i < 8; i++) r[8*i +: 8] = text[i];
    return r;
  endfunction

  // One register write per edge; called right after a rising edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] pattern, logic [3:0] plen, logic [63:0] repl,
                           logic [3:0] rlen, logic case_sens);
    write_reg(CfgPattern, pattern);
    write_reg(CfgPlen, CfgDataW'(plen));
    write_reg(CfgRepl, repl);
    write_reg(CfgRlen, CfgDataW'(rlen));
    write_reg(CfgCaseSens, CfgDataW'(case_sens));
    cfg_we_i <= 1'b0;
  endtask

  // One input transfer. Random gaps before it; valid held until accepted.
  task automatic send_byte(byte_t value, logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_string(byte_q_t text);
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  // Sender goes quiet until nothing is outstanding, then lets the window settle.
  // The first edge is always taken so the pending count includes the last transfer.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    byte_q_t       str_q;
    logic [63:0]   pattern, repl;
    logic [3:0]    plen_reg, rlen_reg;
    logic          case_sens;
    int unsigned   eff_plen, target, pick, sent;
    byte_t         b;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // reset settings: one-byte NUL pattern, empty replacement, so NULs vanish
    send_string('{8'h00, 8'hff});
    wait_drain();

    // case-insensitive two-byte pattern, longer replacement
    configure(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3, 1'b0);
    send_string(text_bytes("zABab"));
    wait_drain();

    // full-width pattern: a short string passes through, then a hit of 8 bytes
    // gives the most results one item can cause
    configure(pack_text("ABCDEFGH"), 4'd8, '1, 4'd8, 1'b1);
    send_string(text_bytes("ABC"));
    send_string(text_bytes("ABCDEFGH"));
    wait_drain();

    // out-of-range lengths: pattern length 0 acts as 1, replacement 15 as 8
    configure(pack_text("q"), 4'd0, pack_text("01234567"), 4'd15, 1'b1);
    send_string(text_bytes("q"));
    wait_drain();

    // pattern shortened mid-string: three bytes sit in the window, then the
    // pattern drops to two bytes before the string goes on
    configure(pack_text("wxyz"), 4'd4, pack_text("--"), 4'd2, 1'b1);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    wait_drain();
    configure(pack_text("wx"), 4'd2, pack_text("--"), 4'd2, 1'b1);
    send_byte("w", 1'b0);
    send_byte("x", 1'b1);
    wait_drain();

    // ---- random phases ----
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase

      // first two phases pin the length extremes
      if (phase == 0) begin
        plen_reg = 4'd1;
        rlen_reg = 4'd0;
      end else if (phase == 1) begin
        plen_reg = 4'd8;
        rlen_reg = 4'd8;
      end else begin
        plen_reg = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) :
                                                 4'($urandom_range(1, 8));
        if (phase == 6) plen_reg = 4'd0;
        rlen_reg = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) :
                                                 4'($urandom_range(0, 8));
      end
      eff_plen = (plen_reg == 0) ? 1 : ((plen_reg > PatternMax) ? PatternMax : plen_reg);

      // pattern from a few letters in mixed case, some raw bytes
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          pattern[8*k +: 8] = 8'($urandom_range(0, 255));
        end else begin
          pattern[8*k +: 8] = 8'("a" + $urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end
      end
      if (phase == 7) pattern = '1;
      repl      = {$urandom, $urandom};
      case_sens = 1'($urandom_range(0, 1));
      configure(pattern, plen_reg, repl, rlen_reg, case_sens);

      // one long receiver hold-off with the sender still pushing
      if (phase == 4) hold_off_req = 1'b1;

      sent = 0;
      while (sent < BytesPerPhase) begin
        str_q.delete();
        target = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_plen) :
                                               $urandom_range(1, 20);
        while (str_q.size() < target) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            // whole pattern, with the odd case flip for near misses
            for (int unsigned k = 0; k < eff_plen; k++) begin
              b = pattern[8*k +: 8];
              if ($urandom_range(0, 3) == 0) b ^= 8'h20;
              str_q.push_back(b);
            end
          end else if (pick < 8) begin
            b = pattern[8*$urandom_range(0, eff_plen - 1) +: 8];
            if ($urandom_range(0, 3) == 0) b ^= 8'h20;
            str_q.push_back(b);
          end else begin
            str_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        while (str_q.size() > target) void'(str_q.pop_back());
        send_string(str_q);
        sent += str_q.size();
      end
      wait_drain();
    end

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("stream_find_and_replace_unit_test: done, clean");
    end else begin
      $display("stream_find_and_replace_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== stream_find_and_replace_unit.f =====
+incdir+src
src/sfr_pkg.sv
src/sfr_window.sv
src/sfr_burst.sv
src/stream_find_and_replace_unit.sv
dv/sfr_rewrite_checker.sv
dv/stream_find_and_replace_unit_test.sv
